// ===== rtl/core/uartq_pkg.sv =====
// Shared types and constants for the UART receive/transmit ring buffer unit.
// Used by the front, the back and the top level; depends on nothing.
`default_nettype none

package uartq_pkg;

  localparam int RX_DEPTH_DEF = 64;
  localparam int TX_DEPTH_DEF = 64;
  localparam int MAX_BURST    = 64;
  localparam int LIMIT_W      = 7;
  localparam int REM_W        = 6;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_BURST = 2'd2,
    REQ_EVENT = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_TX_FULL = 2'd1,
    ST_NO_DATA = 2'd2
  } status_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    req_t               op;
    logic [7:0]         data;     // tx byte on put, received byte on event
    logic [LIMIT_W-1:0] limit;    // saturated burst limit
    logic               err_hit;  // line error to count
    logic               rx_push;  // received byte waiting
    logic               tx_req;   // data register empty
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/uart_rx_tx_ring_buffers_unit.sv =====
// UART receive/transmit ring buffers. A request passes the front queue to the
// back end, which registers its result; a get, burst or event that sends first
// reads its byte from a buffer RAM through the POP or SEND state. A burst gives
// one byte per cycle after its first while the result is not stalled, and the
// back end takes no new command until a popping request's last byte is out.
// Synchronous reset empties both queues, clears the error count and the enable.
`default_nettype none

module uart_rx_tx_ring_buffers_unit #(
  parameter int RX_DEPTH = uartq_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = uartq_pkg::TX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  tx_byte,
  input  logic [6:0]  read_limit,
  input  logic        flag_error,
  input  logic [4:0]  error_status,
  input  logic        flag_rx_complete,
  input  logic [7:0]  rx_data,
  input  logic        flag_data_empty,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [7:0]  rx_byte,
  output logic        rx_valid,
  output logic        send_valid,
  output logic [7:0]  send_byte,
  output logic        empty_irq_enable,
  output logic [31:0] error_count,
  output logic        rx_available,
  output logic        tx_drained,
  output logic        last
);
  import uartq_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  uartq_front u_front (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req_type         (req_type),
    .tx_byte          (tx_byte),
    .read_limit       (read_limit),
    .flag_error       (flag_error),
    .error_status     (error_status),
    .flag_rx_complete (flag_rx_complete),
    .rx_data          (rx_data),
    .flag_data_empty  (flag_data_empty),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_take         (cmd_take)
  );

  uartq_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_take         (cmd_take),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .status           (status),
    .rx_byte          (rx_byte),
    .rx_valid         (rx_valid),
    .send_valid       (send_valid),
    .send_byte        (send_byte),
    .empty_irq_enable (empty_irq_enable),
    .error_count      (error_count),
    .rx_available     (rx_available),
    .tx_drained       (tx_drained),
    .last             (last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/uartq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module uartq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/uartq_front.sv =====
// Front end: accepts request items, classifies them and queues commands.
// Depends on uartq_pkg.
`default_nettype none

module uartq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [1:0]        req_type,
  input  logic [7:0]        tx_byte,
  input  logic [6:0]        read_limit,
  input  logic              flag_error,
  input  logic [4:0]        error_status,
  input  logic              flag_rx_complete,
  input  logic [7:0]        rx_data,
  input  logic              flag_data_empty,
  output logic              cmd_valid,
  output uartq_pkg::cmd_t   cmd,
  input  logic              cmd_take
);
  import uartq_pkg::*;

  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in         = '0;
    cmd_in.op      = req_t'(req_type);
    cmd_in.data    = (req_t'(req_type) == REQ_PUT) ? tx_byte : rx_data;
    cmd_in.limit   = (read_limit > LIMIT_W'(MAX_BURST)) ? LIMIT_W'(MAX_BURST) : read_limit;
    cmd_in.err_hit = flag_error && (error_status != 5'd0);
    cmd_in.rx_push = flag_rx_complete;
    cmd_in.tx_req  = flag_data_empty;
  end

  assign req_stall = (count == 2'd2);
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cmd_in;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (cmd_take) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, cmd_take};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/uartq_back.sv =====
// Back end: owns both ring buffers and their pointers, executes commands and
// holds the result register. Depends on uartq_pkg and uartq_ram.
`default_nettype none

module uartq_back #(
  parameter int RX_DEPTH = uartq_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = uartq_pkg::TX_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  uartq_pkg::cmd_t   cmd,
  output logic              cmd_take,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [1:0]        status,
  output logic [7:0]        rx_byte,
  output logic              rx_valid,
  output logic              send_valid,
  output logic [7:0]        send_byte,
  output logic              empty_irq_enable,
  output logic [31:0]       error_count,
  output logic              rx_available,
  output logic              tx_drained,
  output logic              last
);
  import uartq_pkg::*;

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEND
  } state_t;

  state_t           state, state_next;
  logic [RX_AW-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [TX_AW-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
  logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;
  logic [31:0]      err_cnt, err_cnt_next;
  logic             irq_on, irq_on_next;
  logic [REM_W-1:0] rem, rem_next;

  logic             out_free;
  logic             emit;
  status_t          e_status;
  logic [7:0]       e_rx_byte, e_send_byte;
  logic             e_rx_valid, e_send_valid, e_last;
  logic             rx_empty, rx_full, tx_empty, tx_full, fin;

  logic             rx_we, rx_re, tx_we, tx_re;
  logic [7:0]       rx_rdata, tx_rdata;

  assign rx_head_inc = (rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
  assign rx_tail_inc = (rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
  assign tx_head_inc = (tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
  assign tx_tail_inc = (tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail + 1'b1;

  assign rx_empty = (rx_head == rx_tail);
  assign rx_full  = (rx_head_inc == rx_tail);
  assign tx_empty = (tx_head == tx_tail);
  assign tx_full  = (tx_head_inc == tx_tail);
  // the tail already points past the byte being delivered
  assign fin      = (rx_tail == rx_head) || (rem == '0);
  assign out_free = !res_valid || !res_stall;

  uartq_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head),
    .wdata (cmd.data),
    .re    (rx_re),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  uartq_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head),
    .wdata (cmd.data),
    .re    (tx_re),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

  always_comb begin
    state_next   = state;
    rx_head_next = rx_head;
    rx_tail_next = rx_tail;
    tx_head_next = tx_head;
    tx_tail_next = tx_tail;
    err_cnt_next = err_cnt;
    irq_on_next  = irq_on;
    rem_next     = rem;
    cmd_take     = 1'b0;
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    tx_we        = 1'b0;
    tx_re        = 1'b0;
    emit         = 1'b0;
    e_status     = ST_DONE;
    e_rx_byte    = 8'd0;
    e_rx_valid   = 1'b0;
    e_send_valid = 1'b0;
    e_send_byte  = 8'd0;
    e_last       = 1'b1;

    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          case (cmd.op)
            REQ_PUT: begin
              emit = 1'b1;
              if (tx_full) begin
                e_status = ST_TX_FULL;
              end else begin
                tx_we        = 1'b1;
                tx_head_next = tx_head_inc;
                irq_on_next  = 1'b1;
              end
            end
            REQ_GET, REQ_BURST: begin
              if (rx_empty) begin
                emit     = 1'b1;
                e_status = ST_NO_DATA;
              end else if (cmd.op == REQ_BURST && cmd.limit == '0) begin
                emit = 1'b1;
              end else begin
                // issue the first read; the byte returns next cycle
                rx_re        = 1'b1;
                rx_tail_next = rx_tail_inc;
                rem_next     = (cmd.op == REQ_BURST) ? REM_W'(cmd.limit - 1'b1) : '0;
                state_next   = S_POP;
              end
            end
            REQ_EVENT: begin
              err_cnt_next = err_cnt + {31'd0, cmd.err_hit} + {31'd0, cmd.rx_push && rx_full};
              if (cmd.rx_push && !rx_full) begin
                rx_we        = 1'b1;
                rx_head_next = rx_head_inc;
              end
              if (cmd.tx_req && !tx_empty) begin
                tx_re        = 1'b1;
                tx_tail_next = tx_tail_inc;
                state_next   = S_SEND;
              end else begin
                if (cmd.tx_req) begin
                  irq_on_next = 1'b0;
                end
                emit = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          emit       = 1'b1;
          e_rx_byte  = rx_rdata;
          e_rx_valid = 1'b1;
          e_last     = fin;
          if (fin) begin
            state_next = S_IDLE;
          end else begin
            // chain the next read of the burst
            rx_re        = 1'b1;
            rx_tail_next = rx_tail_inc;
            rem_next     = rem - 1'b1;
          end
        end
      end
      S_SEND: begin
        if (out_free) begin
          emit         = 1'b1;
          e_send_valid = 1'b1;
          e_send_byte  = tx_rdata;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status           <= e_status;
      rx_byte          <= e_rx_byte;
      rx_valid         <= e_rx_valid;
      send_valid       <= e_send_valid;
      send_byte        <= e_send_byte;
      empty_irq_enable <= irq_on_next;
      error_count      <= err_cnt_next;
      // a burst result reports the queue as it stands after its own pop
      rx_available     <= (state == S_POP) ? (rx_head != rx_tail)
                                           : (rx_head_next != rx_tail_next);
      tx_drained       <= (tx_head_next == tx_tail_next);
      last             <= e_last;
    end
    if (rst) begin
      state     <= S_IDLE;
      rx_head   <= '0;
      rx_tail   <= '0;
      tx_head   <= '0;
      tx_tail   <= '0;
      err_cnt   <= '0;
      irq_on    <= 1'b0;
      rem       <= '0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rx_head <= rx_head_next;
      rx_tail <= rx_tail_next;
      tx_head <= tx_head_next;
      tx_tail <= tx_tail_next;
      err_cnt <= err_cnt_next;
      irq_on  <= irq_on_next;
      rem     <= rem_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
